// File: rtl/sha_pkg.sv
// sha_pkg: shared types, constants and functions for the sha-256 block compressor
// holds the initial hash value, the round constant table, sigma functions and fsm state type
// no dependencies
package sha_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 16;
  localparam int unsigned NumRnds  = 64;
  localparam int unsigned NumVars  = 8;
  localparam int unsigned CntW     = $clog2(NumRnds);
  localparam int unsigned IdxW     = $clog2(NumVars);

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumVars-1:0] vars_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } sha_state_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
  } sha_ctl_t;

  localparam vars_t INIT_HASH = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [NumRnds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction

  function automatic word_t small_s0(input word_t v);
    small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_s1(input word_t v);
    small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t big_s0(input word_t v);
    big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_s1(input word_t v);
    big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

endpackage

// File: rtl/sha_sched.sv
// sha_sched: sixteen-word message schedule window as a shift line
// loads message words, then produces one schedule word per round
// depends on sha_pkg
module sha_sched (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  input  sha_pkg::word_t    load_word,
  output sha_pkg::word_t    wt
);

  sha_pkg::word_t win_r [sha_pkg::NumWords];
  sha_pkg::word_t exp_word;

  // word t+16 from the window holding words t..t+15
  assign exp_word = sha_pkg::small_s1(win_r[14]) + win_r[9]
                  + sha_pkg::small_s0(win_r[1]) + win_r[0];

  assign wt = win_r[0];

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.step) begin
      for (int i = 0; i < sha_pkg::NumWords - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sha_pkg::NumWords-1] <= ctl.load ? load_word : exp_word;
    end
  end

endmodule

// File: rtl/sha_round.sv
// sha_round: working variables a..h and the shared round unit, one round per step
// reloads the initial hash value on reset and on init
// depends on sha_pkg
module sha_round (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sha_pkg::sha_ctl_t          ctl,
  input  logic [sha_pkg::CntW-1:0]   rnd,
  input  sha_pkg::word_t             wt,
  output sha_pkg::vars_t             vars
);

  sha_pkg::vars_t vars_r;
  sha_pkg::vars_t vars_nxt;
  sha_pkg::word_t t1;
  sha_pkg::word_t t2;
  sha_pkg::word_t va, vb, vc, vd, ve, vf, vg, vh;

  assign va = vars_r[0];
  assign vb = vars_r[1];
  assign vc = vars_r[2];
  assign vd = vars_r[3];
  assign ve = vars_r[4];
  assign vf = vars_r[5];
  assign vg = vars_r[6];
  assign vh = vars_r[7];

  always_comb begin
    t1 = vh + sha_pkg::big_s1(ve) + ((ve & vf) ^ (~ve & vg)) + sha_pkg::ROUND_K[rnd] + wt;
    t2 = sha_pkg::big_s0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));
    vars_nxt    = vars_r;
    vars_nxt[0] = t1 + t2;
    vars_nxt[1] = va;
    vars_nxt[2] = vb;
    vars_nxt[3] = vc;
    vars_nxt[4] = vd + t1;
    vars_nxt[5] = ve;
    vars_nxt[6] = vf;
    vars_nxt[7] = vg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      vars_r <= sha_pkg::INIT_HASH;
    end else if (ctl.step) begin
      vars_r <= vars_nxt;
    end
  end

  assign vars = vars_r;

endmodule

// File: rtl/sha256_block_compress.sv
// sha256_block_compress: takes 16 message words (one per cycle while ready), then runs
// 64 rounds at one round per cycle through the shared round unit, then offers 8 digest words
// in_ready is low during rounds/output
// synchronous active-low reset returns to loading with the initial hash value in a..h
module sha256_block_compress (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_message_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [31:0]               out_digest_word,
  output logic [2:0]                out_digest_index,
  output logic                      out_last_word
);

  sha_pkg::sha_state_t            state_r, state_nxt;
  logic [sha_pkg::CntW-1:0]       cnt_r, cnt_nxt;
  sha_pkg::sha_ctl_t              ctl;
  sha_pkg::word_t                 wt;
  sha_pkg::vars_t                 vars;
  logic [sha_pkg::IdxW-1:0]       idx;
  logic                           in_acc;
  logic                           out_acc;

  localparam logic [sha_pkg::CntW-1:0] LastLoad = sha_pkg::CntW'(sha_pkg::NumWords - 1);
  localparam logic [sha_pkg::CntW-1:0] LastRnd  = sha_pkg::CntW'(sha_pkg::NumRnds - 1);
  localparam logic [sha_pkg::CntW-1:0] LastOut  = sha_pkg::CntW'(sha_pkg::NumVars - 1);

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign idx     = cnt_r[sha_pkg::IdxW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      sha_pkg::ST_LOAD: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LastLoad) begin
            cnt_nxt   = '0;
            state_nxt = sha_pkg::ST_ROUND;
          end
        end
      end
      sha_pkg::ST_ROUND: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LastRnd) begin
          cnt_nxt   = '0;
          state_nxt = sha_pkg::ST_OUT;
        end
      end
      sha_pkg::ST_OUT: begin
        if (out_acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LastOut) begin
            cnt_nxt   = '0;
            state_nxt = sha_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = sha_pkg::ST_LOAD;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctl       = '0;
    case (state_r)
      sha_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        ctl.load = in_acc;
      end
      sha_pkg::ST_ROUND: begin
        ctl.step = 1'b1;
      end
      sha_pkg::ST_OUT: begin
        out_valid = 1'b1;
        ctl.init  = out_acc && (cnt_r == LastOut);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  sha_sched u_sched (
    .clk       (clk),
    .ctl       (ctl),
    .load_word (in_message_word),
    .wt        (wt)
  );

  sha_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rnd   (cnt_r),
    .wt    (wt),
    .vars  (vars)
  );

  assign out_digest_word  = vars[idx] + sha_pkg::INIT_HASH[idx];
  assign out_digest_index = idx;
  assign out_last_word    = (cnt_r == LastOut);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output handshakes open together");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_digest_index == '0))
    else $error("digest does not start at word zero");

  a_rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_ROUND && cnt_r == LastRnd) |=> out_valid)
    else $error("output not offered after last round");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_word) |=> (in_ready && cnt_r == '0))
    else $error("block not ready for next word after last digest word");

  a_hold_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_digest_word))
    else $error("digest word changed while stalled");

endmodule
